### rtl/pbhu_pkg.sv
// shared types, constants and the nibble decode function of the packed bcd/hex unpacker
// no dependencies
`timescale 1ns / 1ps

package pbhu_pkg;

  // decode_mode codes
  localparam logic [1:0] MODE_BCD_LEFT  = 2'd0;
  localparam logic [1:0] MODE_BCD_RIGHT = 2'd1;
  localparam logic [1:0] MODE_HEX       = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_DECODE_MODE = 2'd0;
  localparam logic [1:0] REG_DIGIT_COUNT = 2'd1;
  localparam logic [1:0] REG_FILL_IS_F   = 2'd2;

  localparam logic [6:0] ASCII_ZERO  = 7'h30;
  localparam logic [6:0] ASCII_A     = 7'h41;
  localparam logic [6:0] ASCII_CARET = 7'h5E;
  localparam logic [3:0] NIB_SEP     = 4'hD;
  localparam logic [3:0] NIB_NINE    = 4'h9;
  localparam logic [3:0] NIB_F       = 4'hF;

  // digit counts for which the track 2 separator applies (exclusive bounds)
  localparam logic [9:0] TRACK2_LO = 10'd17;
  localparam logic [9:0] TRACK2_HI = 10'd38;

  localparam int unsigned CNT_W = 10;

  typedef struct packed {
    logic [6:0] ascii_char;
    logic       error;
    logic       last;
  } pbhu_res_t;

  typedef struct packed {
    logic [CNT_W-1:0] byte_position;
    logic             separator_seen;
    logic             field_failed;
  } pbhu_state_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       ok;
    logic       sep_set;
  } pbhu_nib_t;

  function automatic pbhu_nib_t decode_nib(input logic [3:0] nib, input logic hex,
                                           input logic track2, input logic sep_seen);
    pbhu_nib_t r;
    r.sep_set = 1'b0;
    r.ok      = 1'b1;
    r.ch      = ASCII_ZERO + {3'b000, nib};
    if (hex) begin
      if (nib > NIB_NINE) begin
        r.ch = 7'(ASCII_A + {3'b000, nib} - 7'd10);
      end
    end else if (track2 && !sep_seen && nib == NIB_SEP) begin
      r.ch      = ASCII_CARET;
      r.sep_set = 1'b1;
    end else if (nib > NIB_NINE) begin
      r.ok = 1'b0;
      r.ch = 7'd0;
    end
    return r;
  endfunction

endpackage

### rtl/pbhu_decode.sv
// combinational decode of one packed byte into up to two result characters
// depends on pbhu_pkg
`timescale 1ns / 1ps

module pbhu_decode #(
  parameter int unsigned MAX_DIGITS = 1023
) (
  input  logic [7:0]                 data_byte,
  input  logic [1:0]                 decode_mode,
  input  logic [pbhu_pkg::CNT_W-1:0] digit_count,
  input  logic                       fill_is_f,
  input  pbhu_pkg::pbhu_state_t      st,
  output pbhu_pkg::pbhu_state_t      st_nxt,
  output logic [1:0]                 n_res,
  output pbhu_pkg::pbhu_res_t        res0,
  output pbhu_pkg::pbhu_res_t        res1
);

  localparam logic [11:0] MaxDig = 12'(MAX_DIGITS);

  logic [pbhu_pkg::CNT_W-1:0] cnt_nz;
  logic [pbhu_pkg::CNT_W-1:0] cnt;
  logic [pbhu_pkg::CNT_W:0]   nbytes;
  logic                       odd, first, lastb, hex, track2;
  logic [3:0]                 fill, hi, lo;
  pbhu_pkg::pbhu_nib_t        d_hi, d_lo;
  pbhu_pkg::pbhu_res_t        err_res;
  logic                       sep_mid, fail_new;

  assign cnt_nz = (digit_count == '0) ? pbhu_pkg::CNT_W'(1) : digit_count;
  assign cnt    = ({2'b00, cnt_nz} > MaxDig) ? pbhu_pkg::CNT_W'(MaxDig) : cnt_nz;
  assign nbytes = ({1'b0, cnt} + 11'd1) >> 1;
  assign odd    = cnt[0];
  assign first  = (st.byte_position == '0);
  assign lastb  = ({1'b0, st.byte_position} + 11'd1) >= nbytes;
  assign hex    = decode_mode[1];
  assign track2 = !hex && cnt > pbhu_pkg::TRACK2_LO && cnt < pbhu_pkg::TRACK2_HI;
  assign fill   = fill_is_f ? pbhu_pkg::NIB_F : 4'h0;
  assign hi     = data_byte[7:4];
  assign lo     = data_byte[3:0];

  assign err_res = '{ascii_char: 7'd0, error: 1'b1, last: 1'b1};

  // high nibble is decoded first and may consume the separator
  assign d_hi    = pbhu_pkg::decode_nib(hi, hex, track2, st.separator_seen);
  assign sep_mid = st.separator_seen | d_hi.sep_set;

  always_comb begin
    n_res    = 2'd0;
    res0     = err_res;
    res1     = err_res;
    fail_new = 1'b0;
    d_lo     = pbhu_pkg::decode_nib(lo, hex, track2, sep_mid);
    st_nxt   = st;
    if (!st.field_failed) begin
      if (decode_mode == pbhu_pkg::MODE_BCD_LEFT) begin
        if (!d_hi.ok) begin
          n_res    = 2'd1;
          fail_new = 1'b1;
        end else if (odd && lastb) begin
          // low nibble of the last byte is fill
          if (lo != fill) begin
            n_res    = 2'd2;
            res0     = '{ascii_char: d_hi.ch, error: 1'b0, last: 1'b0};
            fail_new = 1'b1;
          end else begin
            n_res = 2'd1;
            res0  = '{ascii_char: d_hi.ch, error: 1'b0, last: 1'b1};
          end
          st_nxt.separator_seen = sep_mid;
        end else begin
          n_res = 2'd2;
          res0  = '{ascii_char: d_hi.ch, error: 1'b0, last: 1'b0};
          if (!d_lo.ok) begin
            fail_new = 1'b1;
          end else begin
            res1 = '{ascii_char: d_lo.ch, error: 1'b0, last: lastb};
          end
          st_nxt.separator_seen = sep_mid | d_lo.sep_set;
        end
      end else begin
        if (odd && first) begin
          // high nibble of the first byte is fill
          if (hi != fill) begin
            n_res    = 2'd1;
            fail_new = 1'b1;
          end else begin
            d_lo  = pbhu_pkg::decode_nib(lo, hex, track2, st.separator_seen);
            n_res = 2'd1;
            if (!d_lo.ok) begin
              fail_new = 1'b1;
            end else begin
              res0 = '{ascii_char: d_lo.ch, error: 1'b0, last: lastb};
            end
            st_nxt.separator_seen = st.separator_seen | d_lo.sep_set;
          end
        end else if (!d_hi.ok) begin
          n_res    = 2'd1;
          fail_new = 1'b1;
        end else begin
          n_res = 2'd2;
          res0  = '{ascii_char: d_hi.ch, error: 1'b0, last: 1'b0};
          if (!d_lo.ok) begin
            fail_new = 1'b1;
          end else begin
            res1 = '{ascii_char: d_lo.ch, error: 1'b0, last: lastb};
          end
          st_nxt.separator_seen = sep_mid | d_lo.sep_set;
        end
      end
    end
    st_nxt.field_failed = st.field_failed | fail_new;
    st_nxt.byte_position = st.byte_position + pbhu_pkg::CNT_W'(1);
    if (lastb) begin
      st_nxt = '0;
    end
  end

endmodule

### rtl/pbhu_outq.sv
// four-entry result queue: up to two pushes and one pop per cycle
// depends on pbhu_pkg
`timescale 1ns / 1ps

module pbhu_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_n,
  input  pbhu_pkg::pbhu_res_t push0,
  input  pbhu_pkg::pbhu_res_t push1,
  output logic                room2,
  output logic                q_valid,
  input  logic                q_pop,
  output pbhu_pkg::pbhu_res_t q_head
);

  pbhu_pkg::pbhu_res_t mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign q_valid = (cnt_r != 3'd0);
  assign room2   = (cnt_r <= 3'd2);
  assign q_head  = mem_r[rd_ptr_r];
  assign pop     = q_valid && q_pop;

  assign wr_ptr_nxt = wr_ptr_r + push_n;
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
  assign cnt_nxt    = cnt_r + {1'b0, push_n} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push1;
    end
  end

endmodule

### rtl/packed_bcd_hex_unpacker.sv
// top level of the packed bcd/hex unpacker: input register, decode, result queue, config
// depends on pbhu_pkg, pbhu_decode, pbhu_outq
`timescale 1ns / 1ps

// Packed BCD / hex unpacker. Each input request carries one byte of a packed
// field; the block gives one ASCII character per data nibble, so a byte yields
// zero, one or two result requests. The field is digit_count nibbles long in
// (digit_count+1)/2 bytes; decode_mode picks BCD left-justified, BCD
// right-justified or hex, and fill_is_f the expected pad nibble for odd counts.
// An invalid nibble or a wrong pad gives a single error result (ascii_char 0,
// error 1, last 1) and the rest of the field is swallowed while still counted.
// Timing: a byte is held in the input register, then decoded and pushed into a
// four-entry result queue whose head drives the output. While out_stall is low,
// the output side drains one character per cycle, and bytes that yield one
// character or none can be taken every cycle. The queue admits a byte only
// with room for two results, which sets the sustained rate. Configuration
// writes are taken at any time (cfg_ready is always high) and must only
// happen while idle.
module packed_bcd_hex_unpacker #(
  parameter int unsigned MAX_DIGITS = 1023
) (
  input  logic       clk,
  input  logic       rst_n,
  // input bytes
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  // result characters
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_ascii_char,
  output logic       out_error,
  output logic       out_last,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  // configuration registers
  logic [1:0] decode_mode_r;
  logic [9:0] digit_count_r;
  logic       fill_is_f_r;

  // input register
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_take, advance;

  // field state
  pbhu_pkg::pbhu_state_t st_r, st_nxt;

  logic [1:0]          n_res, push_n;
  pbhu_pkg::pbhu_res_t res0, res1, q_head;
  logic                room2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r <= pbhu_pkg::MODE_BCD_LEFT;
      digit_count_r <= 10'd1;
      fill_is_f_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pbhu_pkg::REG_DECODE_MODE: decode_mode_r <= cfg_data[1:0];
        pbhu_pkg::REG_DIGIT_COUNT: digit_count_r <= cfg_data;
        pbhu_pkg::REG_FILL_IS_F:   fill_is_f_r   <= cfg_data[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // the held byte moves on once the queue can take two results
  assign advance    = in_vld_r && room2;
  assign in_stall   = in_vld_r && !room2;
  assign in_take    = in_valid && !in_stall;
  assign in_vld_nxt = in_take || (in_vld_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_data_byte;
    end
  end

  pbhu_decode #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_decode (
    .data_byte  (in_byte_r),
    .decode_mode(decode_mode_r),
    .digit_count(digit_count_r),
    .fill_is_f  (fill_is_f_r),
    .st         (st_r),
    .st_nxt     (st_nxt),
    .n_res      (n_res),
    .res0       (res0),
    .res1       (res1)
  );

  // field state follows each decoded byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  assign push_n = advance ? n_res : 2'd0;

  pbhu_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (push_n),
    .push0  (res0),
    .push1  (res1),
    .room2  (room2),
    .q_valid(out_valid),
    .q_pop  (!out_stall),
    .q_head (q_head)
  );

  assign out_ascii_char = q_head.ascii_char;
  assign out_error      = q_head.error;
  assign out_last       = q_head.last;

endmodule

### rtl/pbhu_checker.sv
// port-level checks for the packed bcd/hex unpacker, bound to the top level
// depends on packed_bcd_hex_unpacker
`timescale 1ns / 1ps

module pbhu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] out_ascii_char,
  input logic       out_error,
  input logic       out_last
);

  // an error result always closes the field
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last)
    else $error("error result without last");

  // an error result carries no character
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_ascii_char == 7'd0)
    else $error("error result with nonzero character");

  // a good result always carries a character
  a_ok_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error |-> out_ascii_char != 7'd0)
    else $error("good result with zero character");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ascii_char)
      && $stable(out_error) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind packed_bcd_hex_unpacker pbhu_checker u_pbhu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_ascii_char(out_ascii_char),
  .out_error     (out_error),
  .out_last      (out_last)
);

### tb/sv/packed_bcd_hex_unpacker_test.sv
// self-checking testbench for packed_bcd_hex_unpacker: predicts every character from
// its own field decoder and compares the result channel against it
// depends on pbhu_pkg and the rtl of packed_bcd_hex_unpacker
`timescale 1ns / 1ps

module packed_bcd_hex_unpacker_test;

  localparam int unsigned DIGIT_LIMIT = 1023;
  // unused selector value, decodes like hex
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // random bytes outside the large field
  localparam int unsigned RANDOM_ITEMS = 270;

  // expected characters of the byte stream, kept in arrival order
  class char_board;
    logic [1:0]  mode;
    logic [9:0]  digits;
    logic        fill_f;
    logic [9:0]  byte_pos;
    logic        sep_seen;
    logic        failed;
    int unsigned max_digits;
    int unsigned failures;
    pbhu_pkg::pbhu_res_t pending[$];

    function new(int unsigned lim);
      max_digits = lim;
      mode       = pbhu_pkg::MODE_BCD_LEFT;
      digits     = 10'd1;
      fill_f     = 1'b0;
      byte_pos   = '0;
      sep_seen   = 1'b0;
      failed     = 1'b0;
      failures   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [9:0] val);
      case (idx)
        pbhu_pkg::REG_DECODE_MODE: mode = val[1:0];
        pbhu_pkg::REG_DIGIT_COUNT: digits = val;
        pbhu_pkg::REG_FILL_IS_F:   fill_f = val[0];
        default: ;
      endcase
    endfunction

    // digit count as the block uses it
    function int unsigned field_digits();
      int unsigned n;
      n = (digits == 0) ? 1 : digits;
      if (n > max_digits) n = max_digits;
      return n;
    endfunction

    function bit sep_field();
      int unsigned n;
      n = field_digits();
      return mode < pbhu_pkg::MODE_HEX && n > pbhu_pkg::TRACK2_LO && n < pbhu_pkg::TRACK2_HI;
    endfunction

    // zero means the nibble is not a legal digit
    function logic [6:0] nib_char(logic [3:0] nib, bit hex, bit t2);
      if (hex) begin
        return (nib > pbhu_pkg::NIB_NINE) ? pbhu_pkg::ASCII_A + 7'(nib) - 7'd10
                                          : pbhu_pkg::ASCII_ZERO + 7'(nib);
      end
      if (t2 && !sep_seen && nib == pbhu_pkg::NIB_SEP) begin
        sep_seen = 1'b1;
        return pbhu_pkg::ASCII_CARET;
      end
      if (nib > pbhu_pkg::NIB_NINE) return 7'd0;
      return pbhu_pkg::ASCII_ZERO + 7'(nib);
    endfunction

    function void put(logic [6:0] ch, logic err, logic fin);
      pbhu_pkg::pbhu_res_t r;
      r.ascii_char = ch;
      r.error      = err;
      r.last       = fin;
      pending = {pending, r};
    endfunction

    function void flag_error();
      put(7'd0, 1'b1, 1'b1);
      failed = 1'b1;
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned n;
      int unsigned nbytes;
      bit odd, first, lastb, hex, t2, ok;
      logic [3:0] hi, lo, pad;
      logic [6:0] ch;
      n      = field_digits();
      nbytes = (n + 1) / 2;
      odd    = n[0];
      first  = byte_pos == 0;
      lastb  = (byte_pos + 1) >= nbytes;
      hex    = mode >= pbhu_pkg::MODE_HEX;
      t2     = sep_field();
      pad    = fill_f ? pbhu_pkg::NIB_F : 4'h0;
      hi     = b[7:4];
      lo     = b[3:0];
      if (!failed) begin
        if (mode == pbhu_pkg::MODE_BCD_LEFT) begin
          ch = nib_char(hi, 1'b0, t2);
          if (ch == 0) begin
            flag_error();
          end else if (odd && lastb) begin
            if (lo != pad) begin
              put(ch, 1'b0, 1'b0);
              flag_error();
            end else begin
              put(ch, 1'b0, 1'b1);
            end
          end else begin
            put(ch, 1'b0, 1'b0);
            ch = nib_char(lo, 1'b0, t2);
            if (ch == 0) flag_error();
            else put(ch, 1'b0, lastb);
          end
        end else begin
          ok = 1'b1;
          if (odd && first) begin
            if (hi != pad) begin
              flag_error();
              ok = 1'b0;
            end
          end else begin
            ch = nib_char(hi, hex, t2);
            if (ch == 0) begin
              flag_error();
              ok = 1'b0;
            end else begin
              put(ch, 1'b0, 1'b0);
            end
          end
          if (ok) begin
            ch = nib_char(lo, hex, t2);
            if (ch == 0) flag_error();
            else put(ch, 1'b0, lastb);
          end
        end
      end
      if (lastb) begin
        byte_pos = '0;
        sep_seen = 1'b0;
        failed   = 1'b0;
      end else begin
        byte_pos = byte_pos + 10'd1;
      end
    endfunction

    function void check_char(pbhu_pkg::pbhu_res_t got);
      pbhu_pkg::pbhu_res_t want;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: char %h error %b last %b",
                   got.ascii_char, got.error, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.ascii_char !== want.ascii_char || got.error !== want.error ||
          got.last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected char %h error %b last %b, got char %h error %b last %b",
                   want.ascii_char, want.error, want.last,
                   got.ascii_char, got.error, got.last);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_ascii_char;
  logic       out_error;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = pbhu_pkg::REG_DECODE_MODE;
  logic [9:0] cfg_data = 10'd0;

  // percent of cycles in which the sender holds back or the receiver stalls
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  char_board board = new(DIGIT_LIMIT);

  packed_bcd_hex_unpacker #(.MAX_DIGITS(DIGIT_LIMIT)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ascii_char(out_ascii_char),
    .out_error     (out_error),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: check each accepted character, then pick next cycle's stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_char({out_ascii_char, out_error, out_last});
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // next byte for the current field position: mostly legal digits with the
  // right pad, an occasional separator nibble, and some raw noise bytes
  function automatic logic [7:0] plausible_byte();
    int unsigned n;
    int unsigned nbytes;
    bit hex, odd, first, lastb;
    logic [3:0] hi, lo, pad;
    if ($urandom_range(99) < 12) return 8'($urandom_range(255));
    n      = board.field_digits();
    nbytes = (n + 1) / 2;
    odd    = n[0];
    first  = board.byte_pos == 0;
    lastb  = (board.byte_pos + 1) >= nbytes;
    hex    = board.mode >= pbhu_pkg::MODE_HEX;
    hi     = hex ? 4'($urandom_range(15)) : 4'($urandom_range(9));
    lo     = hex ? 4'($urandom_range(15)) : 4'($urandom_range(9));
    // track 2 separator somewhere in the field
    if (board.sep_field() && !board.sep_seen && $urandom_range(5) == 0) begin
      if ($urandom_range(1)) hi = pbhu_pkg::NIB_SEP;
      else lo = pbhu_pkg::NIB_SEP;
    end
    pad = board.fill_f ? pbhu_pkg::NIB_F : 4'h0;
    if (odd && lastb && board.mode == pbhu_pkg::MODE_BCD_LEFT) lo = pad;
    if (odd && first && board.mode != pbhu_pkg::MODE_BCD_LEFT) hi = pad;
    return {hi, lo};
  endfunction

  // one input request, held until the block takes it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    board.take_byte(b);
  endtask

  // one register write request; valid is left high for a following write
  task automatic cfg_write(input logic [1:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
  endtask

  task automatic set_field(input logic [1:0] mode, input logic [9:0] digits,
                           input logic fill);
    cfg_write(pbhu_pkg::REG_DECODE_MODE, {8'd0, mode});
    cfg_write(pbhu_pkg::REG_DIGIT_COUNT, digits);
    cfg_write(pbhu_pkg::REG_FILL_IS_F, {9'd0, fill});
    cfg_valid <= 1'b0;
  endtask

  // wait for every expected character, then let dropped bytes flush out
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int unsigned items;
    logic [9:0]  digits;
    items = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 20;
    recv_stall_pct = 47;

    // left-justified, 3 digits, pad 0: good field, bad low nibble, bad pad
    set_field(pbhu_pkg::MODE_BCD_LEFT, 10'd3, 1'b0);
    send_byte(8'h12);
    send_byte(8'h30);
    send_byte(8'h1A);
    send_byte(8'h00);
    send_byte(8'h12);
    send_byte(8'h35);
    drain();

    // right-justified, pad F in the first high nibble: good field, then wrong pad
    set_field(pbhu_pkg::MODE_BCD_RIGHT, 10'd3, 1'b1);
    send_byte(8'hF1);
    send_byte(8'h23);
    send_byte(8'h01);
    send_byte(8'h23);
    drain();

    // hex letters at both ends of the range
    set_field(pbhu_pkg::MODE_HEX, 10'd4, 1'b0);
    send_byte(8'hFA);
    send_byte(8'h9B);
    drain();

    // spare mode decodes as hex
    set_field(MODE_SPARE, 10'd2, 1'b1);
    send_byte(8'hFF);
    drain();

    // count zero acts as a single digit
    set_field(pbhu_pkg::MODE_BCD_LEFT, 10'd0, 1'b0);
    send_byte(8'h50);
    drain();

    // track 2 length: first D becomes the separator, the second is an error,
    // and the rest of the field is swallowed
    set_field(pbhu_pkg::MODE_BCD_LEFT, 10'd20, 1'b1);
    send_byte(8'h12);
    send_byte(8'h3D);
    send_byte(8'h45);
    send_byte(8'h6D);
    send_byte(8'h78);
    send_byte(8'h90);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'h44);
    drain();

    // random phases: receiver-heavy stall, sender-heavy idle, then full speed
    for (int r = 0; r < 3; r++) begin
      case (r)
        0: begin
          send_idle_pct  = 20;
          recv_stall_pct = 47;
        end
        1: begin
          send_idle_pct  = 47;
          recv_stall_pct = 20;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // one full field at the largest count
          set_field(pbhu_pkg::MODE_HEX, 10'd1023, 1'($urandom_range(1)));
          repeat (512) send_byte(plausible_byte());
          drain();
        end
      endcase
      while (items < (r + 1) * RANDOM_ITEMS / 3) begin
        case ($urandom_range(9))
          0:       digits = 10'd0;
          1:       digits = 10'd1023;
          2:       digits = 10'($urandom_range(1023));
          3, 4, 5: digits = 10'($urandom_range(16, 39));
          default: digits = 10'($urandom_range(1, 12));
        endcase
        // fields often end mid-way here, so the new setting lands mid-field
        set_field(2'($urandom_range(3)), digits, 1'($urandom_range(1)));
        repeat ($urandom_range(4, 40)) begin
          send_byte(plausible_byte());
          items++;
        end
        drain();
      end
    end

    drain();
    if (board.failures == 0 && board.pending.size() == 0) begin
      $display("packed_bcd_hex_unpacker_test OK");
    end else begin
      $display("packed_bcd_hex_unpacker_test NOT OK");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #400000;
    $display("packed_bcd_hex_unpacker_test NOT OK");
    $finish;
  end

endmodule
